[sv/jse_pkg.sv]
// jse_pkg: shared types and constants for the json string escaper
// used by jse_expand, jse_emit and json_string_escaper; no dependencies
package jse_pkg;

    // result status codes
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    // characters used by the escapes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // longest escape sequence and the bits of its length and index
    localparam int SEQ_MAX = 6;
    localparam int LEN_BITS = 3;

    // one item's pending results: sequence bytes, count and status
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] seq;
        logic [LEN_BITS-1:0]     len;
        logic [1:0]              status;
    } jse_item_t;

    // lowercase hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (CH_ZERO + {4'd0, v}) : (CH_LOW_A + {4'd0, v} - 8'd10);
    endfunction

endpackage

[sv/jse_expand.sv]
// jse_expand: maps one source byte to its json escape sequence and length
// depends on jse_pkg
module jse_expand
    import jse_pkg::*;
(
    input  logic [7:0]                in_byte,
    output logic [SEQ_MAX-1:0][7:0]   seq,
    output logic [LEN_BITS-1:0]       len
);

    // escape lookup
    always_comb
    begin
        seq = '0;
        len = LEN_BITS'(1);
        case (in_byte)
            CH_QUOTE:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_QUOTE;  len = LEN_BITS'(2);
            end
            CH_BSLASH:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_BSLASH; len = LEN_BITS'(2);
            end
            CH_BS:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_LOW_B;  len = LEN_BITS'(2);
            end
            CH_FF:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_LOW_F;  len = LEN_BITS'(2);
            end
            CH_LF:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_LOW_N;  len = LEN_BITS'(2);
            end
            CH_CR:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_LOW_R;  len = LEN_BITS'(2);
            end
            CH_TAB:
            begin
                seq[0] = CH_BSLASH; seq[1] = CH_LOW_T;  len = LEN_BITS'(2);
            end
            default:
            begin
                if (in_byte < CTRL_LIMIT)
                begin
                    // other control characters become \u00xx
                    seq[0] = CH_BSLASH;
                    seq[1] = CH_LOW_U;
                    seq[2] = CH_ZERO;
                    seq[3] = CH_ZERO;
                    seq[4] = hex_digit(in_byte[7:4]);
                    seq[5] = hex_digit(in_byte[3:0]);
                    len    = LEN_BITS'(SEQ_MAX);
                end
                else
                begin
                    seq[0] = in_byte;
                end
            end
        endcase
    end

endmodule

[sv/jse_emit.sv]
// jse_emit: holds one item's pending results and sends them one per cycle
// when not stalled, through a registered stream output; depends on jse_pkg
module jse_emit
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  jse_item_t  item,
    output logic       ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // status
    output logic       m_tlast    // run_last
);

    logic                act_valid_reg;
    jse_item_t           act_reg;
    logic [LEN_BITS-1:0] idx_reg;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic [1:0]          out_user_reg;
    logic                out_last_reg;

    logic out_free;
    logic move;
    logic piece_last;

    // pending piece moves when the output register frees up
    assign out_free   = !out_valid_reg || m_tready;
    assign move       = act_valid_reg && out_free;
    assign piece_last = (idx_reg == (act_reg.len - LEN_BITS'(1)));
    assign ready      = !act_valid_reg || (move && piece_last);

    // pending item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            act_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (move && piece_last)
        begin
            act_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            idx_reg <= idx_reg + LEN_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg <= item;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= act_reg.seq[idx_reg];
            out_user_reg <= act_reg.status;
            out_last_reg <= piece_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/json_string_escaper.sv]
// json_string_escaper: top level of the json string escaper
// depends on jse_pkg, jse_expand and jse_emit
//
// Usage:
//   s_tdata carries one source byte per item; a zero byte ends the string.
//   m_tdata carries one output byte, m_tuser its status (data, end, capacity
//   exceeded) and m_tlast marks the final result caused by one source byte.
//   cfg_wr_en / cfg_wr_data write the output capacity (bytes, with room for
//   the terminator), applied to the next item; the user must write it only
//   between items, which the block itself does not enforce.
// A byte's results pass the pending register, then the output register.
// Throughput: while the receiver does not stall, a byte with a single-byte
//   result is accepted every cycle and an escape of n bytes is sent one byte
//   per cycle from the pending register, so the next byte is accepted on the
//   cycle its last piece moves out. Bytes dropped after an overflow give
//   no result.
// Reset clears the byte count, the overflow flag and both valid flags, and
//   sets the capacity to 65535.
// When the receiver stalls, the output register holds its result and the
//   pending register fills; s_tready then drops until the output drains.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic [1:0]  m_tuser,    // status
    output logic        m_tlast,    // run_last
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    logic [COUNT_BITS-1:0] bytes_used_reg;
    logic [COUNT_BITS-1:0] bytes_used_next;
    logic                  overflowed_reg;
    logic                  overflowed_next;
    logic [15:0]           capacity_reg;

    logic                  accept;
    logic                  load;
    jse_item_t             item;
    logic [SEQ_MAX-1:0][7:0] esc_seq;
    logic [LEN_BITS-1:0]   esc_len;
    logic [CW-1:0]         used_ext;
    logic [CW-1:0]         grown;
    logic                  fit_data;
    logic                  fit_end;

    assign accept = s_tvalid && s_tready;

    // escape sequence of the incoming byte
    jse_expand u_expand (
        .in_byte (s_tdata),
        .seq     (esc_seq),
        .len     (esc_len)
    );

    // capacity checks against the running count
    assign used_ext = CW'(bytes_used_reg);
    assign grown    = used_ext + CW'(esc_len);
    assign fit_data = ((grown + CW'(1)) <= CW'(capacity_reg))
                      && (grown <= CW'({COUNT_BITS{1'b1}}));
    assign fit_end  = (used_ext + CW'(1)) <= CW'(capacity_reg);

    // per-item decision
    always_comb
    begin
        bytes_used_next = bytes_used_reg;
        overflowed_next = overflowed_reg;
        load            = 1'b0;
        item.seq        = '0;
        item.len        = LEN_BITS'(1);
        item.status     = ST_OVER;
        if (accept)
        begin
            if (overflowed_reg)
            begin
                if (s_tdata == CH_NUL)
                begin
                    overflowed_next = 1'b0;
                    bytes_used_next = '0;
                end
            end
            else if (s_tdata == CH_NUL)
            begin
                bytes_used_next = '0;
                load            = 1'b1;
                item.status     = fit_end ? ST_END : ST_OVER;
            end
            else if (fit_data)
            begin
                bytes_used_next = grown[COUNT_BITS-1:0];
                load            = 1'b1;
                item.seq        = esc_seq;
                item.len        = esc_len;
                item.status     = ST_DATA;
            end
            else
            begin
                overflowed_next = 1'b1;
                load            = 1'b1;
            end
        end
    end

    // string state and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_used_reg <= '0;
            overflowed_reg <= 1'b0;
            capacity_reg   <= 16'hFFFF;
        end
        else
        begin
            bytes_used_reg <= bytes_used_next;
            overflowed_reg <= overflowed_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // result sequencing and output register
    jse_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .item     (item),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // end and overflow results are always single and last
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_DATA) |-> m_tlast)
        else $error("end or overflow result without last");

    // a taken middle piece is followed at once by the next piece
    a_piece_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an escape sequence");

    // overflow is only entered by an accepted item
    a_ovf_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflowed_reg) |-> $past(s_tvalid && s_tready))
        else $error("overflow flag set without an accepted item");

endmodule

[test/json_string_escaper_tb.sv]
// json_string_escaper_tb: self-checking testbench for the json string escaper
// drives source bytes and capacity writes, predicts the escaped stream in a
// scoreboard class; depends on jse_pkg and json_string_escaper

module json_string_escaper_tb
    import jse_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 6;

    // one expected output item
    typedef struct {
        logic [7:0] ch;
        logic [1:0] st;
        logic       last;
    } escaped_t;

    // escaper prediction and result matching
    class escape_scoreboard;
        bit [15:0]   capacity;
        int unsigned used;
        bit          dropping;
        escaped_t    escaped_q[$];
        int          errors;

        function new();
            capacity = 16'hFFFF;
            used = 0;
            dropping = 0;
            errors = 0;
        endfunction

        function void set_capacity(input bit [15:0] value);
            capacity = value;
        endfunction

        function int pending();
            return escaped_q.size();
        endfunction

        function logic [7:0] nibble_char(input logic [3:0] v);
            if (v < 4'd10)
                return 8'h30 + {4'd0, v};
            return 8'h57 + {4'd0, v};
        endfunction

        function void push(input logic [7:0] ch, input logic [1:0] st, input logic last);
            escaped_t r;
            r.ch = ch;
            r.st = st;
            r.last = last;
            escaped_q.push_back(r);
        endfunction

        // note an accepted source byte; returns the number of results it causes
        function int note_byte(input logic [7:0] c);
            logic [7:0] seq [6];
            int len;
            // rest of an overflowed string is dropped until its terminator
            if (dropping)
            begin
                if (c == CH_NUL)
                begin
                    dropping = 0;
                    used = 0;
                end
                return 0;
            end
            // terminator, or overflow if even the zero byte does not fit
            if (c == CH_NUL)
            begin
                push(CH_NUL, (used + 1 <= capacity) ? ST_END : ST_OVER, 1'b1);
                used = 0;
                return 1;
            end
            // build the escape sequence
            len = 2;
            seq[0] = CH_BSLASH;
            case (c)
                CH_QUOTE, CH_BSLASH: seq[1] = c;
                CH_BS:  seq[1] = CH_LOW_B;
                CH_FF:  seq[1] = CH_LOW_F;
                CH_LF:  seq[1] = CH_LOW_N;
                CH_CR:  seq[1] = CH_LOW_R;
                CH_TAB: seq[1] = CH_LOW_T;
                default:
                begin
                    if (c < CTRL_LIMIT)
                    begin
                        len = 6;
                        seq[1] = CH_LOW_U;
                        seq[2] = CH_ZERO;
                        seq[3] = CH_ZERO;
                        seq[4] = nibble_char(c[7:4]);
                        seq[5] = nibble_char(c[3:0]);
                    end
                    else
                    begin
                        len = 1;
                        seq[0] = c;
                    end
                end
            endcase
            // capacity check keeps room for the terminator
            if (used + len + 1 > capacity || used + len > 32'hFFFF)
            begin
                dropping = 1;
                push(CH_NUL, ST_OVER, 1'b1);
                return 1;
            end
            for (int k = 0; k < len; k++)
                push(seq[k], ST_DATA, k == len - 1);
            used = used + len;
            return len;
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(input logic [7:0] ch, input logic [1:0] st,
                                   input logic last);
            escaped_t r;
            if (escaped_q.size() == 0)
            begin
                errors++;
                $error("out_byte: no result expected, got %h (status %0d)", ch, st);
                return;
            end
            r = escaped_q.pop_front();
            if (ch !== r.ch)
            begin
                errors++;
                $error("out_byte: expected %h, got %h", r.ch, ch);
            end
            if (st !== r.st)
            begin
                errors++;
                $error("status: expected %0d, got %0d", r.st, st);
            end
            if (last !== r.last)
            begin
                errors++;
                $error("run_last: expected %0d, got %0d", r.last, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // out_byte
    logic [1:0]  m_tuser;    // status
    logic        m_tlast;    // run_last
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    escape_scoreboard sb;
    bit               calm;
    int unsigned      cycles;
    int               live_items;

    json_string_escaper uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle count and run limit
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one source item, with an occasional gap first
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        void'(sb.note_byte(b));
        live_items++;
    endtask

    // hold the source until every expected item is out and the block settles
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // capacity write, only while idle
    task automatic write_capacity(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(value);
    endtask

    // random non-zero source character, weighted toward the escape classes
    function automatic logic [7:0] pick_char();
        int pick;
        logic [7:0] named [7];
        named = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
        pick = $urandom_range(99);
        if (pick < 45)
            return 8'($urandom_range(8'h7F, 8'h20));
        if (pick < 70)
            return named[$urandom_range(6)];
        if (pick < 82)
            return 8'($urandom_range(8'h1F, 8'h01));
        return 8'($urandom_range(8'hFF, 8'h80));
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(9))
            0: return 16'd1;
            1: return 16'd2;
            2: return 16'd3;
            3: return 16'd6;
            4: return 16'd7;
            5: return 16'($urandom_range(30, 8));
            6: return 16'hFFFF;
            7: return 16'($urandom_range(16'hFFFF, 1));
            8: return 16'($urandom_range(120, 30));
            default: return 16'($urandom_range(12, 2));
        endcase
    endfunction

    // result side: random stalls, checked at each accepted item
    initial
    begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if (hold > 0)
                hold--;
            else if (!calm && $urandom_range(99) < 6)
                hold = $urandom_range(4, 1);
            m_tready <= (hold == 0);
        end
    end

    // stimulus
    initial
    begin
        logic [7:0] plain_run [15];
        int phase;
        int strings;
        int str_len;
        bit noisy;
        plain_run = '{8'h41, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
                      8'h01, 8'h1F, 8'h7F, 8'hFF, 8'h80, 8'h20, CH_NUL};
        sb = new();
        calm = 0;
        live_items = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every escape class at the reset capacity
        foreach (plain_run[i])
            send_byte(plain_run[i]);
        drain();

        // smallest capacity: only the terminator fits, then overflow and drop
        write_capacity(16'd1);
        send_byte(CH_NUL);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(CH_NUL);
        drain();

        // one plain byte fills a two-byte buffer exactly
        write_capacity(16'd2);
        send_byte(8'h41);
        send_byte(CH_NUL);
        drain();

        // capacity lowered mid-string so the terminator no longer fits
        write_capacity(16'd40);
        send_byte(8'h01);
        drain();
        write_capacity(16'd3);
        send_byte(CH_NUL);
        drain();

        // random strings under changing capacities
        phase = 0;
        while (live_items < 320)
        begin
            calm = (phase >= 4 && phase < 8);
            write_capacity(pick_capacity());
            strings = $urandom_range(4, 1);
            for (int s = 0; s < strings; s++)
            begin
                noisy = ($urandom_range(99) < 8);
                str_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                   : $urandom_range(12);
                for (int k = 0; k < str_len; k++)
                    send_byte(noisy ? 8'($urandom_range(255)) : pick_char());
                // occasionally leave the last string open across a capacity write
                if (s != strings - 1 || $urandom_range(99) >= 15)
                    send_byte(CH_NUL);
            end
            drain();
            phase++;
        end
        calm = 0;

        drain();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/jse_pkg.sv
sv/jse_expand.sv
sv/jse_emit.sv
sv/json_string_escaper.sv
test/json_string_escaper_tb.sv
